### design/lfu_page_replacement_assert.svh
// Assertion macros for the design file that checks its own logic.
// Every check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef LFU_PAGE_REPLACEMENT_ASSERT_SVH
`define LFU_PAGE_REPLACEMENT_ASSERT_SVH

// Whenever cond holds, expr must hold in the same cycle.
`define LFU_PR_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Whenever cond holds, expr must hold in the following cycle.
`define LFU_PR_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### design/lfu_pr_pkg.sv
`default_nettype none

package lfu_pr_pkg;

    // Built capacity and field widths.
    localparam int MAX_FRAMES    = 8;
    localparam int PAGE_BITS     = 16;
    localparam int PAGE_FIELD_W  = 16;
    localparam int COUNT_W       = 32;
    localparam int FRAME_COUNT_W = 4;
    localparam int FRAME_IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 4'd8;

    typedef logic [PAGE_BITS-1:0]     page_t;
    typedef logic [COUNT_W-1:0]       count_t;
    typedef logic [MAX_FRAMES-1:0]    frame_mask_t;
    typedef logic [FRAME_IDX_W-1:0]   frame_idx_t;
    typedef logic [FRAME_COUNT_W-1:0] frame_count_t;

    localparam count_t COUNT_MAX = '1;

    // One reference word.
    typedef struct packed {
        logic [PAGE_FIELD_W-1:0] page_number;
        logic                    last_reference;
    } lfu_pr_req_t;

    // One result word.
    typedef struct packed {
        logic                    fault;
        logic                    evicted_valid;
        logic [PAGE_FIELD_W-1:0] evicted_page;
        count_t                  fault_count;
    } lfu_pr_rsp_t;

    // Outcome of looking up one reference in the frame table.
    typedef struct packed {
        logic  fault;
        logic  evicted_valid;
        page_t evicted_page;
    } lfu_pr_lookup_t;

    // Increment that sticks at the all-ones value.
    function automatic count_t sat_inc(input count_t v);
        return (v == COUNT_MAX) ? v : v + count_t'(1);
    endfunction

    // Frames in use for a frame count setting; zero acts as one and values
    // above the built capacity act as the capacity.
    function automatic frame_mask_t active_mask(input frame_count_t fc);
        frame_mask_t m;
        int          n;
        n = int'(fc);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_FRAMES)
        begin
            n = MAX_FRAMES;
        end
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            m[k] = (k < n);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### design/lfu_pr_victim.sv
`default_nettype none

module lfu_pr_victim (
    input  wire lfu_pr_pkg::frame_mask_t candidate,
    input  wire lfu_pr_pkg::count_t      use_count [lfu_pr_pkg::MAX_FRAMES],
    input  wire lfu_pr_pkg::count_t      load_time [lfu_pr_pkg::MAX_FRAMES],
    input  wire lfu_pr_pkg::page_t       page      [lfu_pr_pkg::MAX_FRAMES],
    output lfu_pr_pkg::frame_idx_t       victim_idx,
    output lfu_pr_pkg::page_t            victim_page
);
    import lfu_pr_pkg::*;

    localparam int LEAVES = 1 << $clog2(MAX_FRAMES);
    localparam int NODES  = 2 * LEAVES - 1;

    // Sort key: lowest use count, then earliest load time. Frames outside
    // the candidate set take the all-ones key so they never win, and their
    // stored contents are never looked at.
    typedef struct packed {
        logic [2*COUNT_W:0] key;
        frame_idx_t         idx;
        page_t              page;
    } victim_node_t;

    victim_node_t node [NODES];

    // Binary min tree; the left (lower-numbered) side wins every full tie.
    always_comb
    begin
        for (int i = 0; i < LEAVES; i++)
        begin
            if (i < MAX_FRAMES)
            begin
                node[LEAVES-1+i].key  = candidate[i] ? {1'b0, use_count[i], load_time[i]} : '1;
                node[LEAVES-1+i].idx  = FRAME_IDX_W'(i);
                node[LEAVES-1+i].page = candidate[i] ? page[i] : '0;
            end
            else
            begin
                node[LEAVES-1+i].key  = '1;
                node[LEAVES-1+i].idx  = '0;
                node[LEAVES-1+i].page = '0;
            end
        end
        for (int i = LEAVES - 2; i >= 0; i--)
        begin
            node[i] = (node[2*i+2].key < node[2*i+1].key) ? node[2*i+2] : node[2*i+1];
        end
    end

    assign victim_idx  = node[0].idx;
    assign victim_page = node[0].page;

endmodule

`default_nettype wire

### design/lfu_pr_frames.sv
`default_nettype none

module lfu_pr_frames (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         step,
    input  wire lfu_pr_pkg::page_t      page,
    input  wire                         last,
    input  wire lfu_pr_pkg::frame_mask_t active,
    input  wire                         cfg_clear,
    input  wire lfu_pr_pkg::frame_mask_t cfg_keep,
    output lfu_pr_pkg::lfu_pr_lookup_t  lookup
);
    import lfu_pr_pkg::*;

    // Frame table.
    frame_mask_t valid_reg;
    frame_mask_t valid_next;
    page_t       page_reg [MAX_FRAMES];
    count_t      use_reg  [MAX_FRAMES];
    count_t      load_reg [MAX_FRAMES];
    count_t      ref_count_reg;
    count_t      ref_count_next;

    frame_mask_t hit_vec;
    frame_mask_t free_vec;
    frame_mask_t free_first;
    frame_mask_t victim_vec;
    frame_mask_t load_vec;
    frame_idx_t  victim_idx;
    page_t       victim_page;
    logic        hit;
    logic        has_free;

    // Parallel match of the reference against every resident page.
    always_comb
    begin
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            hit_vec[k] = valid_reg[k] && active[k] && (page_reg[k] == page);
        end
    end

    // Lowest-numbered free frame, as a one-hot vector.
    assign free_vec   = active & ~valid_reg;
    assign free_first = free_vec & (~free_vec + frame_mask_t'(1));
    assign hit        = |hit_vec;
    assign has_free   = |free_vec;

    lfu_pr_victim u_victim (
        .candidate   (active),
        .use_count   (use_reg),
        .load_time   (load_reg),
        .page        (page_reg),
        .victim_idx  (victim_idx),
        .victim_page (victim_page)
    );

    assign victim_vec = frame_mask_t'(1) << victim_idx;

    // On a fault the page goes to a free frame, otherwise over the victim.
    assign load_vec       = hit ? '0 : (has_free ? free_first : victim_vec);
    assign ref_count_next = sat_inc(ref_count_reg);

    assign lookup.fault         = !hit;
    assign lookup.evicted_valid = !hit && !has_free;
    assign lookup.evicted_page  = (!hit && !has_free) ? victim_page : '0;

    // Valid bits: a last word clears the table, a frame count write drops
    // the frames beyond the new count.
    always_comb
    begin
        valid_next = valid_reg;
        if (step)
        begin
            valid_next = last ? '0 : (valid_reg | load_vec);
        end
        else if (cfg_clear)
        begin
            valid_next = valid_reg & cfg_keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            ref_count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (step)
            begin
                ref_count_reg <= last ? '0 : ref_count_next;
            end
        end
    end

    // Per-frame page, use count and load time.
    always_ff @(posedge clk)
    begin
        if (step && !last)
        begin
            for (int k = 0; k < MAX_FRAMES; k++)
            begin
                if (hit_vec[k])
                begin
                    use_reg[k] <= sat_inc(use_reg[k]);
                end
                else if (load_vec[k])
                begin
                    page_reg[k] <= page;
                    use_reg[k]  <= count_t'(1);
                    load_reg[k] <= ref_count_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

### design/lfu_page_replacement.sv
`default_nettype none

`include "lfu_page_replacement_assert.svh"

// LFU page replacer with oldest-load tie-break. Each request word carries a
// page number; the block answers with one result word giving hit or fault,
// the evicted page (zero when nothing is evicted) and the saturating fault
// count of the current sequence. Up to eight frames are tracked in flip-flops,
// and cfg_wdata (written with cfg_we while the block is idle) sets how many
// are in use; writing it drops resident pages above the new count. A word
// with last_reference set clears all frames and counters after its result.
// The block takes one word per clock: a request is registered, then the
// match, free-frame search and least-used min tree over the frames in use
// settle combinationally from the request register, and the result
// register is loaded when the word advances. A stalled result holds the
// request register, which then stalls the input. No clearing pass follows
// reset.
module lfu_page_replacement (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       req_valid,
    output logic                      req_stall,
    input  wire lfu_pr_pkg::lfu_pr_req_t req_data,
    output logic                      rsp_valid,
    input  wire                       rsp_stall,
    output lfu_pr_pkg::lfu_pr_rsp_t   rsp_data,
    input  wire                       cfg_we,
    input  wire lfu_pr_pkg::frame_count_t cfg_wdata
);
    import lfu_pr_pkg::*;

    frame_count_t   frame_count_reg;
    frame_count_t   frame_count_next;
    logic           in_valid_reg;
    logic           in_valid_next;
    lfu_pr_req_t    in_word_reg;
    logic           rsp_valid_reg;
    logic           rsp_valid_next;
    lfu_pr_rsp_t    rsp_word_reg;
    lfu_pr_rsp_t    rsp_word_next;
    count_t         fault_count_reg;
    count_t         fault_count_next;
    count_t         fault_count_inc;
    lfu_pr_lookup_t lookup;
    logic           accept;
    logic           advance;

    // Handshake: the input word moves on whenever the result register is
    // free or being emptied this cycle.
    assign advance   = in_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    assign frame_count_next = cfg_we ? cfg_wdata : frame_count_reg;
    assign in_valid_next    = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign rsp_valid_next   = advance ? 1'b1 : (rsp_stall ? rsp_valid_reg : 1'b0);

    lfu_pr_frames u_frames (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .page      (PAGE_BITS'(in_word_reg.page_number)),
        .last      (in_word_reg.last_reference),
        .active    (active_mask(frame_count_reg)),
        .cfg_clear (cfg_we),
        .cfg_keep  (active_mask(cfg_wdata)),
        .lookup    (lookup)
    );

    // Fault counter and the result word.
    always_comb
    begin
        fault_count_inc  = lookup.fault ? sat_inc(fault_count_reg) : fault_count_reg;
        fault_count_next = fault_count_reg;
        if (advance)
        begin
            fault_count_next = in_word_reg.last_reference ? '0 : fault_count_inc;
        end
        rsp_word_next.fault         = lookup.fault;
        rsp_word_next.evicted_valid = lookup.evicted_valid;
        rsp_word_next.evicted_page  = PAGE_FIELD_W'(lookup.evicted_page);
        rsp_word_next.fault_count   = fault_count_inc;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FRAME_COUNT_RESET;
            in_valid_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            fault_count_reg <= '0;
        end
        else
        begin
            frame_count_reg <= frame_count_next;
            in_valid_reg    <= in_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
            fault_count_reg <= fault_count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= req_data;
        end
        if (advance)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_word_reg;

    // Checks on the pipeline and the counters.
    `LFU_PR_ASSERT_NOW(a_evict_only_on_fault, advance && lookup.evicted_valid, lookup.fault, "eviction without a fault")
    `LFU_PR_ASSERT_NOW(a_no_evict_page_zero, rsp_valid_reg && !rsp_word_reg.evicted_valid, rsp_word_reg.evicted_page == '0, "evicted page not zero")
    `LFU_PR_ASSERT_NEXT(a_fault_count_monotonic, !(advance && in_word_reg.last_reference), fault_count_reg >= $past(fault_count_reg), "fault count went down")
    `LFU_PR_ASSERT_NEXT(a_input_word_held, in_valid_reg && !advance, in_valid_reg && $stable(in_word_reg), "waiting input word lost")

endmodule

`default_nettype wire

### tb/sv/lfu_replacement_checker.sv
// Watches the reference, result and frame count ports of the LFU page
// replacer. It keeps its own copy of the frame table and predicts one result
// word for every accepted reference word. Accepted result words are compared
// in order against those predictions.
module lfu_replacement_checker
    import lfu_pr_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          req_valid,
    input  wire          req_stall,
    input  lfu_pr_req_t  req_data,
    input  wire          rsp_valid,
    input  wire          rsp_stall,
    input  lfu_pr_rsp_t  rsp_data,
    input  wire          cfg_we,
    input  frame_count_t cfg_wdata,
    output int           error_count,
    output int           words_pending
);

    // Predicted frame table and sequence counters.
    page_t        resident_page [MAX_FRAMES];
    logic         resident_valid [MAX_FRAMES];
    count_t       use_cnt [MAX_FRAMES];
    count_t       load_stamp [MAX_FRAMES];
    count_t       ref_seq;
    count_t       fault_total;
    frame_count_t frames_setting;

    // Result words still owed by the block, oldest first.
    lfu_pr_rsp_t  predicted_words [$];
    int           mismatches;

    // Counters stick at all ones.
    function automatic count_t bump(input count_t v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // A setting of zero acts as one frame; values above capacity act as capacity.
    function automatic int active_frames(input frame_count_t fc);
        if (fc == 0)
        begin
            return 1;
        end
        if (int'(fc) > MAX_FRAMES)
        begin
            return MAX_FRAMES;
        end
        return int'(fc);
    endfunction

    // Empty every frame and restart the sequence counters.
    task automatic clear_frames();
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            resident_page[k]  = '0;
            resident_valid[k] = 1'b0;
            use_cnt[k]        = '0;
            load_stamp[k]     = '0;
        end
        ref_seq     = '0;
        fault_total = '0;
    endtask

    // One page reference: hit, fill of a free frame, or least-used eviction
    // with the earliest load losing a tie; a last word then empties every frame.
    task automatic lfu_access(input page_t page, input logic last,
                              output lfu_pr_rsp_t word);
        int n;
        int hit;
        int free_k;
        int victim;
        n      = active_frames(frames_setting);
        hit    = -1;
        free_k = -1;
        word   = '0;
        ref_seq = bump(ref_seq);
        for (int k = 0; k < n; k++)
        begin
            if (resident_valid[k] && resident_page[k] == page && hit < 0)
            begin
                hit = k;
            end
            if (!resident_valid[k] && free_k < 0)
            begin
                free_k = k;
            end
        end
        if (hit >= 0)
        begin
            use_cnt[hit] = bump(use_cnt[hit]);
        end
        else
        begin
            word.fault  = 1'b1;
            fault_total = bump(fault_total);
            // All frames in use are full, so pick the victim.
            if (free_k < 0)
            begin
                victim = 0;
                for (int k = 1; k < n; k++)
                begin
                    if (use_cnt[k] < use_cnt[victim] ||
                        (use_cnt[k] == use_cnt[victim] &&
                         load_stamp[k] < load_stamp[victim]))
                    begin
                        victim = k;
                    end
                end
                word.evicted_valid = 1'b1;
                word.evicted_page  = resident_page[victim][PAGE_FIELD_W-1:0];
                free_k = victim;
            end
            resident_page[free_k]  = page;
            resident_valid[free_k] = 1'b1;
            use_cnt[free_k]        = count_t'(1);
            load_stamp[free_k]     = ref_seq;
        end
        word.fault_count = fault_total;
        if (last)
        begin
            clear_frames();
        end
    endtask

    // Report one field that differs from its prediction.
    task automatic report(input string field, input longint want, input longint got);
        $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    // Sample all three ports at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        lfu_pr_rsp_t want;
        lfu_pr_rsp_t next_word;
        if (!rst_n)
        begin
            clear_frames();
            frames_setting = FRAME_COUNT_RESET;
            predicted_words.delete();
            mismatches = 0;
            error_count   <= 0;
            words_pending <= 0;
        end
        else
        begin
            // Result words are checked before this edge's reference is added.
            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_words.size() == 0)
                begin
                    $display("%0t: result word %h arrived with none expected",
                             $time, rsp_data);
                    mismatches++;
                end
                else
                begin
                    want = predicted_words.pop_front();
                    if (rsp_data.fault !== want.fault)
                    begin
                        report("fault", want.fault, rsp_data.fault);
                    end
                    if (rsp_data.evicted_valid !== want.evicted_valid)
                    begin
                        report("evicted_valid", want.evicted_valid,
                               rsp_data.evicted_valid);
                    end
                    if (rsp_data.evicted_page !== want.evicted_page)
                    begin
                        report("evicted_page", want.evicted_page, rsp_data.evicted_page);
                    end
                    if (rsp_data.fault_count !== want.fault_count)
                    begin
                        report("fault_count", want.fault_count, rsp_data.fault_count);
                    end
                end
            end
            // A smaller frame count drops every frame above it.
            if (cfg_we)
            begin
                frames_setting = cfg_wdata;
                for (int k = active_frames(cfg_wdata); k < MAX_FRAMES; k++)
                begin
                    resident_valid[k] = 1'b0;
                end
            end
            if (req_valid && !req_stall)
            begin
                lfu_access(page_t'(req_data.page_number), req_data.last_reference,
                           next_word);
                predicted_words.insert(predicted_words.size(), next_word);
            end
            error_count   <= mismatches;
            words_pending <= predicted_words.size();
        end
    end

endmodule

### tb/sv/tb_lfu_page_replacement.sv
// Drives page references and frame count settings into the LFU page replacer
// and gives the verdict from the checker's error count.
module tb_lfu_page_replacement
    import lfu_pr_pkg::*;
;

    localparam int QUIET_LIMIT = 3000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         req_valid = 1'b0;
    logic         req_stall;
    lfu_pr_req_t  req_data = '0;
    logic         rsp_valid;
    logic         rsp_stall = 1'b0;
    lfu_pr_rsp_t  rsp_data;
    logic         cfg_we = 1'b0;
    frame_count_t cfg_wdata = '0;

    int error_count;
    int words_pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int frames_now = MAX_FRAMES;
    int quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lfu_page_replacement uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    lfu_replacement_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_data      (req_data),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp_data      (rsp_data),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .error_count   (error_count),
        .words_pending (words_pending)
    );

    // The result side stalls at random at the rate of the current phase.
    always @(posedge clk)
    begin
        rsp_stall <= (int'($urandom_range(0, 99)) < stall_pct);
    end

    // Watchdog: end the run when no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_lfu_page_replacement: FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offer one reference word after a random gap and hold it until accepted.
    task automatic send_word(input logic [PAGE_FIELD_W-1:0] page, input logic last);
        int gap;
        gap = 0;
        while (gap < 40 && int'($urandom_range(0, 99)) < idle_pct)
        begin
            gap++;
        end
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= '{page_number: page, last_reference: last};
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Stop sending and wait until every predicted result word has come back.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    // Frame count writes happen only while the block is idle.
    task automatic write_frames(input frame_count_t value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (value == 0)
        begin
            frames_now = 1;
        end
        else if (int'(value) > MAX_FRAMES)
        begin
            frames_now = MAX_FRAMES;
        end
        else
        begin
            frames_now = int'(value);
        end
    endtask

    // Reference sequences drawn mostly from a small working set so that hits
    // and evictions are common, with wide random and extreme pages mixed in.
    task automatic run_segment(input int count);
        int seq_left;
        int pool_size;
        int pick;
        logic [PAGE_FIELD_W-1:0] pool_base;
        logic [PAGE_FIELD_W-1:0] page;
        logic last;
        seq_left  = 0;
        pool_size = 1;
        pool_base = '0;
        for (int i = 0; i < count; i++)
        begin
            if (seq_left == 0)
            begin
                seq_left  = int'($urandom_range(1, 40));
                pool_base = PAGE_FIELD_W'($urandom);
                pool_size = frames_now + int'($urandom_range(0, 3));
            end
            pick = int'($urandom_range(0, 99));
            if (pick < 80)
            begin
                page = PAGE_FIELD_W'($urandom_range(0, pool_size - 1));
                if ($urandom_range(0, 1))
                begin
                    page = page / 2;
                end
                page = pool_base + page;
            end
            else if (pick < 93)
            begin
                page = PAGE_FIELD_W'($urandom);
            end
            else
            begin
                page = $urandom_range(0, 1) ? '1 : '0;
            end
            // Occasionally a sequence is cut short.
            last = (seq_left == 1) || (int'($urandom_range(0, 99)) < 3);
            seq_left = last ? 0 : seq_left - 1;
            send_word(page, last);
        end
    endtask

    initial
    begin
        int idle_by_phase [4];
        int stall_by_phase [4];
        frame_count_t setting_list [8];
        idle_by_phase  = '{0, 62, 0, 34};
        stall_by_phase = '{0, 0, 62, 34};
        setting_list   = '{4'd15, 4'd1, 4'd8, 4'd4, 4'd0, 4'd7, 4'd2, 4'd8};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Eight frames after reset: extremes, a hit, then a full table where
        // equal use counts fall back to the earliest load.
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        for (int p = 1; p <= 6; p++)
        begin
            send_word(PAGE_FIELD_W'(p), 1'b0);
        end
        send_word(16'h0007, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b1);

        // Two frames: the less used page goes even if loaded later.
        write_frames(4'd2);
        send_word(16'h0010, 1'b0);
        send_word(16'h0011, 1'b0);
        send_word(16'h0010, 1'b0);
        send_word(16'h0012, 1'b0);
        send_word(16'h0011, 1'b1);

        // A setting of zero behaves as a single frame.
        write_frames(4'd0);
        send_word(16'h0020, 1'b0);
        send_word(16'h0020, 1'b0);
        send_word(16'h0021, 1'b1);

        // A setting above capacity behaves as full capacity, and shrinking
        // in the middle of a sequence drops the upper frames.
        write_frames(4'd15);
        for (int p = 16'h40; p <= 16'h44; p++)
        begin
            send_word(PAGE_FIELD_W'(p), 1'b0);
        end
        write_frames(4'd3);
        send_word(16'h0043, 1'b0);
        send_word(16'h0041, 1'b1);

        // Random sequences across frame settings and handshake phases.
        for (int seg = 0; seg < 8; seg++)
        begin
            write_frames(setting_list[seg]);
            idle_pct  = idle_by_phase[seg % 4];
            stall_pct = stall_by_phase[seg % 4];
            run_segment(115);
        end

        drain();
        repeat (5) @(posedge clk);
        if (error_count == 0 && words_pending == 0)
        begin
            $display("tb_lfu_page_replacement: PASS");
        end
        else
        begin
            $display("tb_lfu_page_replacement: FAIL");
        end
        $finish;
    end

endmodule
